// File: src/orfu_pkg.sv
// Shared types, constants and control structs for the overwriting ring FIFO with unescaping reader.
package orfu_pkg;

    localparam int DEPTH = 16384;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [7:0] ESC_BYTE = 8'h01;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] ST_PUT    = 2'd0;
    localparam logic [1:0] ST_DATA   = 2'd1;
    localparam logic [1:0] ST_PREFIX = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic       op;
        logic [7:0] data_in;
    } in_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic [1:0] status;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic do_put;
        logic do_empty;
        logic do_pop;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
    } dp_status_t;

endpackage

// File: src/overwrite_ring_fifo_unescape.sv
// Top level of the overwriting ring FIFO with unescaping reader.
//
// Input channel (in_valid, in_ready, in_data): each transfer carries an op and
// a byte. A put stores the byte in a 16384-entry ring; when the ring is full
// the oldest byte is overwritten. A read pops the oldest byte: 0x01 arms an
// escape flag and reports a consumed prefix, the byte after it comes out
// minus one, and a read of an empty ring reports empty.
// Output channel (out_valid, out_ready, out_data): exactly one result per
// input transfer, in order; data_out is zero unless a byte is delivered.
// A put or an empty read shows its result in the cycle after the input
// transfer; a pop passes through the S_POP state and then the result
// register, because the byte store has a registered read port.
// Puts and empty reads run at one per cycle while the receiver takes each
// result; no input is taken while a pop is in S_POP. The next input
// transfer can happen in the same cycle as the output transfer.
// Reset (rst_n, asynchronous) empties the ring and clears the escape flag; the
// store contents are not cleared and need no sweep.
// When the receiver stalls, the result is held and no input is taken.
module overwrite_ring_fifo_unescape (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  orfu_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output orfu_pkg::out_t out_data
);

    orfu_pkg::cmd_t       cmd;
    orfu_pkg::dp_status_t dp_status;

    orfu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_op     (in_data.op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    orfu_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .put_byte  (in_data.data_in),
        .cmd       (cmd),
        .dp_status (dp_status),
        .out_data  (out_data)
    );

endmodule

// File: src/orfu_datapath.sv
// Datapath: byte store, ring pointers, fill count, escape flag and result register.
module orfu_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          put_byte,
    input  orfu_pkg::cmd_t      cmd,
    output orfu_pkg::dp_status_t dp_status,
    output orfu_pkg::out_t      out_data
);

    logic [7:0]              mem [orfu_pkg::DEPTH];
    logic [7:0]              rd_data_reg;
    logic [orfu_pkg::AW-1:0] write_pos_reg;
    logic [orfu_pkg::AW-1:0] write_pos_next;
    logic [orfu_pkg::AW-1:0] read_pos_reg;
    logic [orfu_pkg::AW-1:0] read_pos_next;
    logic [orfu_pkg::CW-1:0] fill_count_reg;
    logic [orfu_pkg::CW-1:0] fill_count_next;
    logic                    escape_armed_reg;
    logic                    escape_armed_next;
    orfu_pkg::out_t          out_reg;
    orfu_pkg::out_t          out_next;
    logic                    full;
    logic [orfu_pkg::AW-1:0] write_pos_inc;
    logic [orfu_pkg::AW-1:0] read_pos_inc;

    localparam logic [orfu_pkg::AW-1:0] LAST_POS = orfu_pkg::AW'(orfu_pkg::DEPTH - 1);
    localparam logic [orfu_pkg::CW-1:0] FULL_CNT = orfu_pkg::CW'(orfu_pkg::DEPTH);

    assign full          = (fill_count_reg == FULL_CNT);
    assign write_pos_inc = (write_pos_reg == LAST_POS) ? '0 : write_pos_reg + 1'b1;
    assign read_pos_inc  = (read_pos_reg == LAST_POS) ? '0 : read_pos_reg + 1'b1;

    assign dp_status.empty = (fill_count_reg == '0);
    assign out_data        = out_reg;

    // The store is read at the read pointer every cycle; a pop uses the registered
    // data in the cycle after the read transfer.
    always_ff @(posedge clk)
    begin
        if (cmd.do_put)
        begin
            mem[write_pos_reg] <= put_byte;
        end
        rd_data_reg <= mem[read_pos_reg];
    end

    always_comb
    begin
        write_pos_next    = write_pos_reg;
        read_pos_next     = read_pos_reg;
        fill_count_next   = fill_count_reg;
        escape_armed_next = escape_armed_reg;
        out_next          = out_reg;
        if (cmd.do_put)
        begin
            write_pos_next = write_pos_inc;
            if (full)
            begin
                read_pos_next = write_pos_inc;
            end
            else
            begin
                fill_count_next = fill_count_reg + 1'b1;
            end
            out_next.data_out = 8'h00;
            out_next.status   = orfu_pkg::ST_PUT;
        end
        else if (cmd.do_empty)
        begin
            out_next.data_out = 8'h00;
            out_next.status   = orfu_pkg::ST_EMPTY;
        end
        else if (cmd.do_pop)
        begin
            read_pos_next   = read_pos_inc;
            fill_count_next = fill_count_reg - 1'b1;
            if (escape_armed_reg)
            begin
                escape_armed_next = 1'b0;
                out_next.data_out = rd_data_reg - 8'd1;
                out_next.status   = orfu_pkg::ST_DATA;
            end
            else if (rd_data_reg == orfu_pkg::ESC_BYTE)
            begin
                escape_armed_next = 1'b1;
                out_next.data_out = 8'h00;
                out_next.status   = orfu_pkg::ST_PREFIX;
            end
            else
            begin
                out_next.data_out = rd_data_reg;
                out_next.status   = orfu_pkg::ST_DATA;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_pos_reg    <= '0;
            read_pos_reg     <= '0;
            fill_count_reg   <= '0;
            escape_armed_reg <= 1'b0;
        end
        else
        begin
            write_pos_reg    <= write_pos_next;
            read_pos_reg     <= read_pos_next;
            fill_count_reg   <= fill_count_next;
            escape_armed_reg <= escape_armed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

// File: src/orfu_ctrl.sv
// Controller: handshake state machine that sequences puts, pops and result transfers.
module orfu_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_op,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  orfu_pkg::dp_status_t dp_status,
    output orfu_pkg::cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    // A new item may enter in the same cycle the held result is taken.
    assign in_ready  = (state_reg == S_IDLE) || ((state_reg == S_OUT) && out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        case (state_reg)
            S_IDLE, S_OUT:
            begin
                if ((state_reg == S_OUT) && out_ready)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b0;
                end
                if (accept)
                begin
                    if (in_op == orfu_pkg::OP_PUT)
                    begin
                        cmd.do_put     = 1'b1;
                        state_next     = S_OUT;
                        out_valid_next = 1'b1;
                    end
                    else if (dp_status.empty)
                    begin
                        cmd.do_empty   = 1'b1;
                        state_next     = S_OUT;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_POP;
                    end
                end
            end
            S_POP:
            begin
                cmd.do_pop     = 1'b1;
                state_next     = S_OUT;
                out_valid_next = 1'b1;
            end
            default:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: src/orfu_checker.sv
// Port-level checker for the overwriting ring FIFO, bound to the top level.
module orfu_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input orfu_pkg::in_t  in_data,
    input logic           out_valid,
    input logic           out_ready,
    input orfu_pkg::out_t out_data
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // No new input while an earlier result is still waiting.
    a_no_overtake: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");

    // A put reports done on the next cycle.
    a_put_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.op == orfu_pkg::OP_PUT)
        |=> out_valid && (out_data.status == orfu_pkg::ST_PUT))
        else $error("put did not report done");

    // Only a delivered byte carries data.
    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != orfu_pkg::ST_DATA) |-> out_data.data_out == 8'h00)
        else $error("nonzero data without delivery");

endmodule

bind overwrite_ring_fifo_unescape orfu_checker u_orfu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// File: dv/overwrite_ring_fifo_unescape_test.sv
// Self-checking testbench for the overwriting ring FIFO with unescaping reader.
`timescale 1ns / 1ps

module overwrite_ring_fifo_unescape_test;

    // Tracks the ring contents and escape state, and queues the result that each
    // accepted transfer must produce.
    class ring_unescape_tracker;
        logic [7:0]              ring [orfu_pkg::DEPTH];
        logic [orfu_pkg::AW-1:0] wr_pos = '0;
        logic [orfu_pkg::AW-1:0] rd_pos = '0;
        logic [orfu_pkg::CW-1:0] fill_level = '0;
        logic                    armed = 1'b0;
        orfu_pkg::out_t          awaited [$];
        int                      errors = 0;

        function void note_transfer(orfu_pkg::in_t item);
            orfu_pkg::out_t res;
            logic [7:0]     b;
            res.data_out = 8'h00;
            if (item.op == orfu_pkg::OP_PUT)
            begin
                ring[wr_pos] = item.data_in;
                wr_pos = wr_pos + 1'b1;
                // A put into a full ring drops the oldest byte.
                if (int'(fill_level) == orfu_pkg::DEPTH)
                    rd_pos = wr_pos;
                else
                    fill_level = fill_level + 1'b1;
                res.status = orfu_pkg::ST_PUT;
            end
            else if (fill_level == '0)
            begin
                res.status = orfu_pkg::ST_EMPTY;
            end
            else
            begin
                b = ring[rd_pos];
                rd_pos = rd_pos + 1'b1;
                fill_level = fill_level - 1'b1;
                if (armed)
                begin
                    armed = 1'b0;
                    res.data_out = b - 8'd1;
                    res.status = orfu_pkg::ST_DATA;
                end
                else if (b == orfu_pkg::ESC_BYTE)
                begin
                    armed = 1'b1;
                    res.status = orfu_pkg::ST_PREFIX;
                end
                else
                begin
                    res.data_out = b;
                    res.status = orfu_pkg::ST_DATA;
                end
            end
            awaited.push_back(res);
        endfunction

        function void check_result(orfu_pkg::out_t got);
            orfu_pkg::out_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual data_out %02h status %0d",
                         $time, got.data_out, got.status);
                return;
            end
            want = awaited.pop_front();
            if (got.data_out !== want.data_out)
            begin
                errors++;
                $display("%0t: data_out expected %02h, actual %02h",
                         $time, want.data_out, got.data_out);
            end
            if (got.status !== want.status)
            begin
                errors++;
                $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    orfu_pkg::in_t  in_data;
    logic           out_valid;
    logic           out_ready;
    orfu_pkg::out_t out_data;

    ring_unescape_tracker tracker;
    bit quiet_tail = 1'b0;
    bit hold_receiver = 1'b0;

    overwrite_ring_fifo_unescape dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_result(out_data);
    end

    // Receiver: random stalls, plus one long hold-off when the sender asks for it.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_receiver)
            begin
                hold_receiver = 1'b0;
                stall_left = 120;
            end
            else if (stall_left == 0 && !quiet_tail && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 9);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Entered and left at a falling edge.
    task automatic send_item(input logic op, input logic [7:0] b);
        orfu_pkg::in_t item;
        item.op = op;
        item.data_in = b;
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_transfer(item);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (tracker.pending() != 0)
            @(negedge clk);
    endtask

    // Escape bytes and the bytes around them come up often.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0, 1: return orfu_pkg::ESC_BYTE;
            2: return 8'h00;
            3: return 8'hFF;
            4: return 8'h02;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        int put_pct;
        tracker = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty reads, byte extremes, escaped 0x00 and 0x01, and an
        // armed escape that has to survive a put.
        send_item(orfu_pkg::OP_READ, 8'hFF);
        send_item(orfu_pkg::OP_READ, 8'h00);
        send_item(orfu_pkg::OP_PUT, 8'h00);
        send_item(orfu_pkg::OP_PUT, 8'hFF);
        send_item(orfu_pkg::OP_PUT, orfu_pkg::ESC_BYTE);
        send_item(orfu_pkg::OP_PUT, 8'h00);
        send_item(orfu_pkg::OP_PUT, orfu_pkg::ESC_BYTE);
        send_item(orfu_pkg::OP_PUT, orfu_pkg::ESC_BYTE);
        send_item(orfu_pkg::OP_PUT, 8'h7F);
        send_item(orfu_pkg::OP_PUT, orfu_pkg::ESC_BYTE);
        repeat (8) send_item(orfu_pkg::OP_READ, 8'h00);
        send_item(orfu_pkg::OP_PUT, 8'h80);
        send_item(orfu_pkg::OP_READ, 8'hAA);
        send_item(orfu_pkg::OP_PUT, 8'h55);
        send_item(orfu_pkg::OP_READ, 8'h55);
        send_item(orfu_pkg::OP_READ, 8'h00);
        wait_for_results();

        // Random mix; the put share changes per segment so the fill level
        // climbs and drains back to empty.
        for (int seg = 0; seg < 21; seg++)
        begin
            case (seg % 3)
                0: put_pct = 25;
                1: put_pct = 50;
                default: put_pct = 75;
            endcase
            put_pct = put_pct + int'($urandom_range(0, 10)) - 5;
            for (int k = 0; k < 50; k++)
            begin
                if (seg == 8 && k == 0)
                    hold_receiver = 1'b1;
                if (seg == 14 && k == 0)
                    wait_for_results();
                if (int'($urandom_range(0, 99)) < put_pct)
                    send_item(orfu_pkg::OP_PUT, pick_byte());
                else
                    send_item(orfu_pkg::OP_READ, 8'($urandom_range(0, 255)));
            end
        end

        // A put-heavy mix to finish, with no idling in its last part.
        for (int k = 0; k < 250; k++)
        begin
            if (k == 100)
                quiet_tail = 1'b1;
            if ($urandom_range(0, 99) < 60)
                send_item(orfu_pkg::OP_PUT, pick_byte());
            else
                send_item(orfu_pkg::OP_READ, 8'($urandom_range(0, 255)));
        end
        in_valid <= 1'b0;

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (tracker.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
